// ----- design/u2a_pkg.sv -----
package u2a_pkg;

    // Longest digit string the block can produce.
    localparam int unsigned MaxDigits = 16;

    // ASCII anchors for digit characters.
    localparam logic [6:0] ChZero = 7'd48;
    localparam logic [6:0] ChUpperA = 7'd65;

    // Base limits and the bases with their own string width.
    localparam logic [5:0] BaseMin = 6'd2;
    localparam logic [5:0] BaseMax = 6'd36;
    localparam logic [5:0] BaseDec = 6'd10;
    localparam logic [5:0] BaseHex = 6'd16;

    // Fields of one input transfer.
    typedef struct packed {
        logic        mode;
        logic [15:0] value;
        logic [5:0]  base;
        logic [7:0]  buffer_size;
    } item_t;

    // Fields of one result transfer.
    typedef struct packed {
        logic [6:0] character;
        logic [3:0] position;
        logic [4:0] length;
        logic       last;
        logic       empty_res;
    } digit_t;

    // Clamp the base into the range 2 to 36.
    function automatic logic [5:0] clamp_base(input logic [5:0] b);
        logic [5:0] r;
        r = b;
        if (b < BaseMin) begin
            r = BaseMin;
        end else if (b > BaseMax) begin
            r = BaseMax;
        end
        return r;
    endfunction

    // Natural string width for a mode and a clamped base.
    function automatic logic [4:0] natural_width(input logic mode, input logic [5:0] b);
        logic [4:0] w;
        if (b == BaseHex) begin
            w = mode ? 5'd4 : 5'd2;
        end else if (b == BaseDec) begin
            w = mode ? 5'd5 : 5'd3;
        end else begin
            w = mode ? 5'd16 : 5'd8;
        end
        return w;
    endfunction

    // Digit value to its ASCII character.
    function automatic logic [6:0] digit_char(input logic [5:0] d);
        logic [6:0] c;
        if (d > 6'd9) begin
            c = {1'b0, d} - 7'd10 + ChUpperA;
        end else begin
            c = {1'b0, d} + ChZero;
        end
        return c;
    endfunction

endpackage

// ----- design/unsigned_to_ascii_digits_core.sv -----
// Channel  Direction  Handshake           Payload
// item     in         item_valid/stall    u2a_pkg::item_t
// digit    out        digit_valid/stall   u2a_pkg::digit_t
//
// Each digit comes from a restoring division by the base that retires one
// quotient bit per cycle, followed by an emit step; a zero buffer size goes
// straight to the emit step and gives one empty result.
// item_stall is high from the transfer of an item until its last result is
// registered. A stalled digit transfer holds the sequencer in its emit step.
// Reset clears the sequencer and the output valid.
module unsigned_to_ascii_digits_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_stall,
    input  u2a_pkg::item_t  item,
    output logic            digit_valid,
    input  logic            digit_stall,
    output u2a_pkg::digit_t digit
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_EMIT
    } state_t;

    state_t          state_reg, state_next;
    logic [15:0]     quo_reg, quo_next;
    logic [5:0]      rem_reg, rem_next;
    logic [5:0]      base_reg, base_next;
    logic [4:0]      width_reg, width_next;
    logic [3:0]      step_reg, step_next;
    logic [3:0]      idx_reg, idx_next;
    logic            empty_reg, empty_next;
    logic            valid_reg, valid_next;
    u2a_pkg::digit_t out_reg, out_next;

    logic [6:0]  trial;
    logic        fits;
    logic [6:0]  diff;
    logic [5:0]  base_sat;
    logic [4:0]  nat_w;
    logic        out_free;
    logic        is_last;

    assign item_stall  = (state_reg != S_IDLE);
    assign digit_valid = valid_reg;
    assign digit       = out_reg;

    // Shared divider step: shift in the next dividend bit and try a subtract.
    assign trial = {rem_reg, quo_reg[15]};
    assign fits  = (trial >= {1'b0, base_reg});
    assign diff  = trial - {1'b0, base_reg};

    // Setup values for a new item.
    assign base_sat = u2a_pkg::clamp_base(item.base);
    assign nat_w    = u2a_pkg::natural_width(item.mode, base_sat);

    assign out_free = !valid_reg || !digit_stall;
    assign is_last  = empty_reg || ({1'b0, idx_reg} == (width_reg - 5'd1));

    // Sequencer and output register next values.
    always_comb
    begin
        state_next = state_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        base_next  = base_reg;
        width_next = width_reg;
        step_next  = step_reg;
        idx_next   = idx_reg;
        empty_next = empty_reg;
        valid_next = valid_reg;
        out_next   = out_reg;

        // The current result leaves when its transfer completes.
        if (valid_reg && !digit_stall) begin
            valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid) begin
                    quo_next  = item.mode ? item.value : {8'd0, item.value[7:0]};
                    rem_next  = 6'd0;
                    base_next = base_sat;
                    step_next = 4'd0;
                    idx_next  = 4'd0;
                    if ({3'd0, nat_w} > item.buffer_size) begin
                        width_next = item.buffer_size[4:0];
                    end else begin
                        width_next = nat_w;
                    end
                    if (item.buffer_size == 8'd0) begin
                        empty_next = 1'b1;
                        state_next = S_EMIT;
                    end else begin
                        empty_next = 1'b0;
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                quo_next  = {quo_reg[14:0], fits};
                rem_next  = fits ? diff[5:0] : trial[5:0];
                step_next = step_reg + 4'd1;
                if (step_reg == 4'd15) begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_free) begin
                    valid_next = 1'b1;
                    if (empty_reg) begin
                        out_next = '0;
                    end else begin
                        out_next.character = u2a_pkg::digit_char(rem_reg);
                        out_next.position  = 4'(width_reg - 5'd1 - {1'b0, idx_reg});
                        out_next.length    = width_reg;
                        out_next.empty_res = 1'b0;
                    end
                    out_next.last = is_last;
                    out_next.empty_res = empty_reg;
                    if (is_last) begin
                        state_next = S_IDLE;
                    end else begin
                        idx_next   = idx_reg + 4'd1;
                        rem_next   = 6'd0;
                        step_next  = 4'd0;
                        state_next = S_DIV;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
            quo_reg   <= '0;
            rem_reg   <= '0;
            base_reg  <= u2a_pkg::BaseMin;
            width_reg <= '0;
            step_reg  <= '0;
            idx_reg   <= '0;
            empty_reg <= 1'b0;
            valid_reg <= 1'b0;
            out_reg   <= '0;
        end else begin
            state_reg <= state_next;
            quo_reg   <= quo_next;
            rem_reg   <= rem_next;
            base_reg  <= base_next;
            width_reg <= width_next;
            step_reg  <= step_next;
            idx_reg   <= idx_next;
            empty_reg <= empty_next;
            valid_reg <= valid_next;
            out_reg   <= out_next;
        end
    end

endmodule

// ----- design/u2a_checker.sv -----
module u2a_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            item_valid,
    input logic            item_stall,
    input logic            digit_valid,
    input logic            digit_stall,
    input u2a_pkg::digit_t digit
);

    // A stalled result stays offered.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        digit_valid && digit_stall |=> digit_valid)
        else $error("result dropped while stalled");

    // The block is busy right after it takes an item.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> item_stall)
        else $error("block ready right after an input transfer");

    // An empty result always closes its run.
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        digit_valid && digit.empty_res |-> digit.last && digit.length == 5'd0)
        else $error("empty result not flagged last");

    // A character result lies inside its string and the final one sits at index zero.
    a_position: assert property (@(posedge clk) disable iff (!rst_n)
        digit_valid && !digit.empty_res |->
            ({1'b0, digit.position} < digit.length) &&
            (digit.last == (digit.position == 4'd0)))
        else $error("result position outside its string");

endmodule

bind unsigned_to_ascii_digits_core u2a_checker u_u2a_checker (.*);

// ----- sim/u2a_digit_monitor.sv -----
module u2a_digit_monitor (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    input  logic            item_stall,
    input  u2a_pkg::item_t  item,
    input  logic            digit_valid,
    input  logic            digit_stall,
    input  u2a_pkg::digit_t digit,
    output int              mismatches,
    output int              digits_due,
    output int              digits_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    // Digits still to come, oldest first, across all accepted items.
    u2a_pkg::digit_t expected_digits[$];

    // Work out the digit string for one item and queue its characters,
    // least significant digit first.
    function automatic void queue_digit_string(input u2a_pkg::item_t req);
        int              radix;
        int              rest;
        int              span;
        int              rem;
        u2a_pkg::digit_t d;
        radix = int'(req.base);
        if (radix < int'(u2a_pkg::BaseMin))
        begin
            radix = int'(u2a_pkg::BaseMin);
        end
        if (radix > int'(u2a_pkg::BaseMax))
        begin
            radix = int'(u2a_pkg::BaseMax);
        end
        rest = req.mode ? int'(req.value) : int'(req.value[7:0]);

        // A zero buffer size gives a single flagged result and no character.
        if (req.buffer_size == 8'd0)
        begin
            d = '0;
            d.last = 1'b1;
            d.empty_res = 1'b1;
            expected_digits.push_back(d);
            return;
        end

        // String width from mode and base, cut to the buffer and the maximum.
        if (radix == int'(u2a_pkg::BaseHex))
        begin
            span = req.mode ? 4 : 2;
        end
        else if (radix == int'(u2a_pkg::BaseDec))
        begin
            span = req.mode ? 5 : 3;
        end
        else
        begin
            span = req.mode ? 16 : 8;
        end
        if (span > int'(req.buffer_size))
        begin
            span = int'(req.buffer_size);
        end
        if (span > int'(u2a_pkg::MaxDigits))
        begin
            span = int'(u2a_pkg::MaxDigits);
        end

        for (int k = 0; k < span; k++)
        begin
            rem = rest % radix;
            rest = rest / radix;
            if (rem > 9)
            begin
                d.character = 7'(rem - 10 + int'(u2a_pkg::ChUpperA));
            end
            else
            begin
                d.character = 7'(rem + int'(u2a_pkg::ChZero));
            end
            d.position = 4'(span - 1 - k);
            d.length = 5'(span);
            d.last = (k == span - 1);
            d.empty_res = 1'b0;
            expected_digits.push_back(d);
        end
    endfunction

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatches++;
        end
    endtask

    // Compare each digit transfer first, then queue the digits of a new item;
    // the last digit of one item may leave in the same cycle the next is taken.
    always @(posedge clk)
    begin : watch_channels
        u2a_pkg::digit_t want;
        if (rst_n)
        begin
            if (digit_valid && !digit_stall)
            begin
                digits_checked++;
                if (expected_digits.size() == 0)
                begin
                    $error("digit transfer with nothing expected: character %0d position %0d",
                           digit.character, digit.position);
                    mismatches++;
                end
                else
                begin
                    want = expected_digits.pop_front();
                    check_field("character", 32'(want.character), 32'(digit.character));
                    check_field("position", 32'(want.position), 32'(digit.position));
                    check_field("length", 32'(want.length), 32'(digit.length));
                    check_field("last", 32'(want.last), 32'(digit.last));
                    check_field("empty_res", 32'(want.empty_res), 32'(digit.empty_res));
                end
            end
            if (item_valid && !item_stall)
            begin
                queue_digit_string(item);
            end
            digits_due = expected_digits.size();
        end
    end

endmodule

// ----- sim/tb_unsigned_to_ascii_digits_core.sv -----
module tb_unsigned_to_ascii_digits_core;
    timeunit 1ns;
    timeprecision 1ps;

    // Cycles without any transfer before the run is declared hung.
    localparam int QuietLimit = 3000;
    // Quiet time after the last digit, longer than one full item.
    localparam int SettleCycles = 300;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            item_valid = 1'b0;
    logic            item_stall;
    u2a_pkg::item_t  item = '0;
    logic            digit_valid;
    logic            digit_stall = 1'b0;
    u2a_pkg::digit_t digit;

    int mismatches;
    int digits_due;
    int digits_checked;
    int items_sent = 0;
    int zero_room_items = 0;
    int send_idle_pct = 11;
    int digit_stall_pct = 80;

    unsigned_to_ascii_digits_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .item        (item),
        .digit_valid (digit_valid),
        .digit_stall (digit_stall),
        .digit       (digit)
    );

    u2a_digit_monitor digit_monitor (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .item           (item),
        .digit_valid    (digit_valid),
        .digit_stall    (digit_stall),
        .digit          (digit),
        .mismatches     (mismatches),
        .digits_due     (digits_due),
        .digits_checked (digits_checked)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Receiver back-pressure at the current rate.
    always @(posedge clk)
    begin
        digit_stall <= ($urandom_range(99) < digit_stall_pct);
    end

    // Present one item after a random idle gap and hold it until the transfer.
    task automatic send_item(input logic m, input logic [15:0] v, input logic [5:0] b,
                             input logic [7:0] room);
        u2a_pkg::item_t req;
        int             gap;
        req.mode = m;
        req.value = v;
        req.base = b;
        req.buffer_size = room;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
        begin
            gap++;
        end
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= req;
        do
            @(posedge clk);
        while (item_stall !== 1'b0);
        items_sent++;
        if (room == 8'd0)
        begin
            zero_room_items++;
        end
    endtask

    // Random items, weighted toward the widths that decimal and hex get,
    // with some bases outside 2 to 36 and some zero buffer sizes.
    task automatic send_random_items(input int count);
        logic        m;
        logic [15:0] v;
        logic [5:0]  b;
        logic [7:0]  room;
        int          pick;
        repeat (count)
        begin
            m = 1'($urandom_range(1));
            pick = $urandom_range(99);
            if (pick < 10)
            begin
                v = 16'h0000;
            end
            else if (pick < 20)
            begin
                v = 16'hFFFF;
            end
            else
            begin
                v = 16'($urandom());
            end
            pick = $urandom_range(99);
            if (pick < 25)
            begin
                b = u2a_pkg::BaseDec;
            end
            else if (pick < 50)
            begin
                b = u2a_pkg::BaseHex;
            end
            else if (pick < 88)
            begin
                b = 6'($urandom_range(36, 2));
            end
            else
            begin
                b = 6'($urandom_range(63));
            end
            pick = $urandom_range(99);
            if (pick < 8)
            begin
                room = 8'd0;
            end
            else if (pick < 50)
            begin
                room = 8'($urandom_range(16, 1));
            end
            else
            begin
                room = 8'($urandom_range(255, 17));
            end
            send_item(m, v, b, room);
        end
    endtask

    // Hang detection: no transfer on either channel for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QuietLimit)
        begin
            @(posedge clk);
            if ((item_valid && !item_stall) || (digit_valid && !digit_stall))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("** unsigned_to_ascii_digits_core: FAILED **");
        $finish;
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Field extremes and natural widths in both modes.
        send_item(1'b0, 16'h0000, u2a_pkg::BaseDec, 8'hFF);
        send_item(1'b0, 16'h00FF, u2a_pkg::BaseHex, 8'hFF);
        send_item(1'b0, 16'h00FF, 6'd2, 8'd8);
        send_item(1'b1, 16'hFFFF, 6'd2, 8'hFF);
        send_item(1'b1, 16'hFFFF, 6'd36, 8'h80);
        send_item(1'b1, 16'hFFFF, u2a_pkg::BaseDec, 8'd5);
        send_item(1'b1, 16'hBEEF, u2a_pkg::BaseHex, 8'h55);
        send_item(1'b1, 16'h0000, 6'd7, 8'hAA);
        // Zero buffer size.
        send_item(1'b1, 16'd1234, u2a_pkg::BaseDec, 8'd0);
        send_item(1'b0, 16'hFFFF, 6'd0, 8'd0);
        // Bases below two and above thirty-six saturate.
        send_item(1'b0, 16'h00A5, 6'd0, 8'd8);
        send_item(1'b0, 16'h005A, 6'd1, 8'd20);
        send_item(1'b1, 16'hFFFF, 6'd37, 8'd16);
        send_item(1'b1, 16'h1234, 6'd63, 8'hFF);
        // Buffer shorter than the width drops the high digits; the last one equals it.
        send_item(1'b1, 16'hFFFF, u2a_pkg::BaseDec, 8'd2);
        send_item(1'b0, 16'h00FF, u2a_pkg::BaseDec, 8'd1);
        send_item(1'b1, 16'd12345, u2a_pkg::BaseDec, 8'd3);
        send_item(1'b1, 16'h8000, 6'd3, 8'd16);
        // Upper value bits are ignored in 8-bit mode; then a 16-bit value in base 11.
        send_item(1'b0, 16'hFF00, u2a_pkg::BaseHex, 8'd2);
        send_item(1'b0, 16'h0023, 6'd36, 8'd1);
        send_item(1'b1, 16'h5555, 6'd11, 8'd200);

        send_random_items(150);
        send_idle_pct = 80;
        digit_stall_pct <= 11;
        send_random_items(150);
        send_idle_pct = 0;
        digit_stall_pct <= 0;
        send_random_items(150);
        item_valid <= 1'b0;

        @(posedge clk);
        while (digits_due != 0)
        begin
            @(posedge clk);
        end
        repeat (SettleCycles) @(posedge clk);

        $display("Covered %0d item transfers (%0d with zero buffer size) and %0d digit transfers,",
                 items_sent, zero_room_items, digits_checked);
        $display("in both modes, bases 0 to 63, under three pacing profiles on each channel.");
        if (mismatches == 0 && digits_due == 0)
        begin
            $display("** unsigned_to_ascii_digits_core: PASSED **");
        end
        else
        begin
            $display("** unsigned_to_ascii_digits_core: FAILED **");
        end
        $finish;
    end

endmodule
